// ----- rtl/fpq_pkg.sv -----
// ----------------------------------------------------------------------------
// fpq_pkg: shared types and constants of the framed packet queue
// Op and status codes, store geometry, and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpq_pkg;

	localparam int SLOTS        = 16;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int COUNT_W      = $clog2(SLOTS + 1);
	localparam int SLOT_BYTES   = 256;
	localparam int BYTE_W       = $clog2(SLOT_BYTES);
	localparam int ADDR_W       = SLOT_W + BYTE_W;
	localparam int MAX_PAYLOAD  = 255;
	localparam int HEADER_BYTES = 4;
	localparam int OFFSET_W     = 9;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DROP  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load;       // capture the request fields
		logic       mem_wr;     // write payload byte, advance push offset
		logic       commit;     // close the open packet into its slot
		logic       drop_wr;    // update the drop flag
		logic       drop_val;
		logic       pop_adv;    // read next byte of oldest packet
		logic       clear;      // reset pointers, count and counter
		logic       res_load;   // load the result registers
		logic [1:0] res_status;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] op;
		logic       eop;
		logic       count_zero;
		logic       slots_full;
		logic       offset_zero;
		logic       offset_max;
		logic       dropping;
	} stat_t;

endpackage

// ----- rtl/framed_packet_queue_core.sv -----
// ----------------------------------------------------------------------------
// framed_packet_queue_core: ring queue of whole framed packets
// Stores up to 16 packets of up to 255 payload bytes and returns them byte by
// byte behind a four-byte header of length and sequence number.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, executes in the
// following cycle while busy is high, and its result is presented for
// exactly one cycle with done high in the cycle after that. The result
// cannot be held off; sample it while done is high. A new request may be
// issued in the same cycle that done is high, but none is taken during the
// execute cycle, in which busy is high and the payload memory is written or
// read. There is no clearing pass after reset: the stores are only read for
// committed packets.
//
// Requests (op): push a payload byte with its end-of-packet mark, pop the
// next byte of the oldest packet, or clear the whole queue. A packet that
// starts while all slots are taken is dropped in full (status 1 on each of
// its bytes); bytes past 255 are discarded with status 3, but the end mark
// still commits the packet. A popped packet yields length low, length high,
// sequence low, sequence high, then payload; last_byte marks its final byte.
// A pop on an empty queue returns status 2. packets_stored is the count of
// committed packets after the request.
// ----------------------------------------------------------------------------
module framed_packet_queue_core import fpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [7:0]         data_in,
	input  logic               end_of_packet,
	output logic               done,
	output logic [7:0]         data_out,
	output logic               last_byte,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] packets_stored
);

	cmd_t  cmd;
	stat_t stat;

	// sequence each request: capture, execute, strobe the result
	fpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	// hold the packet stores, pointers and result registers
	fpq_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (op),
		.data_in        (data_in),
		.end_of_packet  (end_of_packet),
		.data_out       (data_out),
		.last_byte      (last_byte),
		.status         (status),
		.packets_stored (packets_stored)
	);

	// busy drops in the cycle after it is raised
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("execute phase longer than one cycle");

	// a result strobe follows an execute cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without execute cycle");

	// an empty pop leaves nothing stored
	a_empty_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (packets_stored == '0))
		else $error("empty status with packets stored");

	// a packet end is only reported on a successful pop
	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_byte) |-> (status == ST_OK))
		else $error("last byte with error status");

	// the count never exceeds the slot count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		packets_stored <= COUNT_W'(SLOTS)) else $error("stored count overflow");

endmodule

// ----- rtl/fpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpq_ctrl: request sequencer of the framed packet queue
// Captures a request, then decodes it against the queue status into
// datapath commands in the execute state, and raises the result strobe.
// ----------------------------------------------------------------------------
module fpq_ctrl import fpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;
	logic start_drop;
	logic drop_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// a packet that starts while every slot is taken is discarded whole
	assign start_drop = !stat.dropping && stat.offset_zero && stat.slots_full;
	assign drop_now   = stat.dropping || start_drop;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.res_status = ST_OK;
		if (state_q == S_EXEC) begin
			cmd.res_load = 1'b1;
			case (stat.op)
				OP_PUSH: begin
					if (drop_now) begin
						cmd.drop_wr    = 1'b1;
						cmd.drop_val   = !stat.eop;
						cmd.res_status = ST_DROP;
					end else begin
						if (stat.offset_max) cmd.res_status = ST_TRUNC;
						else                 cmd.mem_wr     = 1'b1;
						cmd.commit = stat.eop;
					end
				end
				OP_POP: begin
					if (stat.count_zero) cmd.res_status = ST_EMPTY;
					else                 cmd.pop_adv    = 1'b1;
				end
				OP_CLEAR: cmd.clear = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/fpq_datapath.sv -----
// ----------------------------------------------------------------------------
// fpq_datapath: storage and pointers of the framed packet queue
// Payload memory, per-slot length and sequence, ring pointers, offsets,
// sequence counter and the result registers.
// ----------------------------------------------------------------------------
module fpq_datapath import fpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         op,
	input  logic [7:0]         data_in,
	input  logic               end_of_packet,
	output logic [7:0]         data_out,
	output logic               last_byte,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] packets_stored
);

	logic [7:0]          payload_mem [SLOTS*SLOT_BYTES];
	logic [7:0]          slot_len_q  [SLOTS];
	logic [15:0]         slot_seq_q  [SLOTS];

	logic [1:0]          op_q;
	logic [7:0]          data_q;
	logic                eop_q;

	logic [SLOT_W-1:0]   wr_slot_q;
	logic [SLOT_W-1:0]   rd_slot_q;
	logic [COUNT_W-1:0]  count_q;
	logic [15:0]         seq_q;
	logic [OFFSET_W-1:0] push_off_q;
	logic [OFFSET_W-1:0] pop_off_q;
	logic                dropping_q;

	logic [7:0]          mem_rd_q;
	logic [7:0]          res_byte_q;
	logic                res_mem_q;
	logic                last_q;
	logic [1:0]          status_q;

	logic [7:0]          rd_len;
	logic [15:0]         rd_seq;
	logic [9:0]          pop_next;
	logic [9:0]          pop_total;
	logic                pop_last;
	logic [7:0]          hdr_byte;
	logic [7:0]          commit_len;
	logic [BYTE_W-1:0]   pay_idx;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;

	assign rd_len    = slot_len_q[rd_slot_q];
	assign rd_seq    = slot_seq_q[rd_slot_q];
	assign pop_next  = {1'b0, pop_off_q} + 10'd1;
	assign pop_total = {2'b00, rd_len} + 10'(HEADER_BYTES);
	assign pop_last  = (pop_next >= pop_total);
	assign pay_idx   = BYTE_W'(pop_off_q - OFFSET_W'(HEADER_BYTES));
	assign rd_addr   = {rd_slot_q, pay_idx};
	assign wr_addr   = {wr_slot_q, push_off_q[BYTE_W-1:0]};

	// length high byte is always zero for an 8-bit length
	always_comb begin
		case (pop_off_q)
			9'd0:    hdr_byte = rd_len;
			9'd2:    hdr_byte = rd_seq[7:0];
			9'd3:    hdr_byte = rd_seq[15:8];
			default: hdr_byte = 8'd0;
		endcase
	end

	assign commit_len = cmd.mem_wr ? 8'(push_off_q + 9'd1) : push_off_q[7:0];

	assign stat.op          = op_q;
	assign stat.eop         = eop_q;
	assign stat.count_zero  = (count_q == '0);
	assign stat.slots_full  = (count_q >= COUNT_W'(SLOTS));
	assign stat.offset_zero = (push_off_q == '0);
	assign stat.offset_max  = (push_off_q >= OFFSET_W'(MAX_PAYLOAD));
	assign stat.dropping    = dropping_q;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) payload_mem[wr_addr] <= data_q;
		if (cmd.pop_adv) mem_rd_q <= payload_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_len_q[wr_slot_q] <= commit_len;
			slot_seq_q[wr_slot_q] <= seq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			data_q <= data_in;
			eop_q  <= end_of_packet;
		end
		if (cmd.res_load) begin
			res_byte_q <= cmd.pop_adv ? hdr_byte : 8'd0;
			res_mem_q  <= cmd.pop_adv && (pop_off_q >= OFFSET_W'(HEADER_BYTES));
			last_q     <= cmd.pop_adv && pop_last;
			status_q   <= cmd.res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			count_q    <= '0;
			seq_q      <= '0;
			push_off_q <= '0;
			pop_off_q  <= '0;
			dropping_q <= 1'b0;
		end else if (cmd.clear) begin
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			count_q    <= '0;
			seq_q      <= '0;
			push_off_q <= '0;
			pop_off_q  <= '0;
			dropping_q <= 1'b0;
		end else begin
			if (cmd.drop_wr) dropping_q <= cmd.drop_val;
			if (cmd.commit) begin
				wr_slot_q  <= next_slot(wr_slot_q);
				count_q    <= count_q + 1'b1;
				seq_q      <= seq_q + 16'd1;
				push_off_q <= '0;
			end else if (cmd.mem_wr) begin
				push_off_q <= push_off_q + 1'b1;
			end
			if (cmd.pop_adv) begin
				if (pop_last) begin
					pop_off_q <= '0;
					rd_slot_q <= next_slot(rd_slot_q);
					count_q   <= count_q - 1'b1;
				end else begin
					pop_off_q <= pop_off_q + 1'b1;
				end
			end
		end
	end

	assign data_out       = res_mem_q ? mem_rd_q : res_byte_q;
	assign last_byte      = last_q;
	assign status         = status_q;
	assign packets_stored = count_q;

endmodule

// ----- dv/tb_framed_packet_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_queue_core: self-checking bench for the framed packet queue
// Drives push, pop and clear requests through the start/busy handshake.
// A table of directed requests runs first, then a stream of packets
// with random content. Every result is checked against a hand-written
// value or a predictor of the queue kept in this bench.
// ----------------------------------------------------------------------------
module tb_framed_packet_queue_core;
	import fpq_pkg::*;

	localparam int RANDOM_REQUESTS = 100;
	localparam int PHASE_LEN       = 25;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 6;

	// One result as the block presents it
	typedef struct packed {
		logic [7:0]         data;
		logic               last;
		logic [1:0]         status;
		logic [COUNT_W-1:0] stored;
	} pkt_result_t;

	// A result still owed by the block, tagged with its request number
	typedef struct {
		pkt_result_t res;
		int          id;
	} pending_t;

	// One row of the directed table
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  data;
		logic        eop;
		int          reps;
		bit          known;
		pkt_result_t res;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         op = OP_POP;
	logic [7:0]         data_in = 8'h00;
	logic               end_of_packet = 1'b0;
	logic               done;
	logic [7:0]         data_out;
	logic               last_byte;
	logic [1:0]         status;
	logic [COUNT_W-1:0] packets_stored;

	// Predictor copy of the queue
	logic [7:0]  q_bytes [SLOTS*SLOT_BYTES];
	logic [7:0]  q_len   [SLOTS];
	logic [15:0] q_seq   [SLOTS];
	int          wr_slot, rd_slot, n_stored, wr_off, rd_off;
	logic [15:0] seq_next;
	bit          in_drop;

	pending_t    expected_results [$];
	plan_row_t   directed_plan [$];

	int n_errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_packets_out = 0;
	int n_dropped = 0;
	int n_truncated = 0;
	int n_empty = 0;
	int peak_stored = 0;
	int cycles = 0;
	bit idling_on = 1'b1;

	framed_packet_queue_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.data_in        (data_in),
		.end_of_packet  (end_of_packet),
		.done           (done),
		.data_out       (data_out),
		.last_byte      (last_byte),
		.status         (status),
		.packets_stored (packets_stored)
	);

	always #5 clk = ~clk;

	// Hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still owed", $time,
				cycles, expected_results.size());
			$display("tb_framed_packet_queue_core: FAIL");
			$finish;
		end
	end

	// Reset the predictor to its post-reset state; a clear request does the same.
	function automatic void empty_queue_model();
		wr_slot  = 0;
		rd_slot  = 0;
		n_stored = 0;
		wr_off   = 0;
		rd_off   = 0;
		seq_next = 16'h0000;
		in_drop  = 1'b0;
	endfunction

	// Advance the predictor by one request and return the result it owes.
	function automatic void model_request(input logic [1:0] req_op, input logic [7:0] req_byte,
			input logic req_eop, output pkt_result_t res);
		int len;
		res = '0;
		case (req_op)
			OP_PUSH: begin
				// A packet that opens on a full queue is discarded up to its end mark
				if (!in_drop && wr_off == 0 && n_stored >= SLOTS)
					in_drop = 1'b1;
				if (in_drop) begin
					if (req_eop)
						in_drop = 1'b0;
					res.status = ST_DROP;
				end else begin
					if (wr_off < MAX_PAYLOAD) begin
						q_bytes[wr_slot*SLOT_BYTES + wr_off] = req_byte;
						wr_off++;
					end else begin
						res.status = ST_TRUNC;
					end
					// The end mark commits even a truncated packet
					if (req_eop) begin
						q_len[wr_slot] = 8'(wr_off);
						q_seq[wr_slot] = seq_next;
						seq_next = seq_next + 16'd1;
						wr_slot = (wr_slot + 1) % SLOTS;
						n_stored++;
						wr_off = 0;
					end
				end
			end
			OP_POP: begin
				if (n_stored == 0) begin
					res.status = ST_EMPTY;
				end else begin
					len = q_len[rd_slot];
					// Header is length low/high then sequence low/high, then payload
					case (rd_off)
						0: res.data = 8'(len);
						1: res.data = 8'(len >> 8);
						2: res.data = q_seq[rd_slot][7:0];
						3: res.data = q_seq[rd_slot][15:8];
						default: res.data = q_bytes[rd_slot*SLOT_BYTES +
							((rd_off - HEADER_BYTES) & (SLOT_BYTES - 1))];
					endcase
					if (rd_off + 1 >= len + HEADER_BYTES) begin
						res.last = 1'b1;
						rd_off = 0;
						rd_slot = (rd_slot + 1) % SLOTS;
						n_stored--;
					end else begin
						rd_off++;
					end
				end
			end
			OP_CLEAR: empty_queue_model();
			default: ;
		endcase
		res.stored = COUNT_W'(n_stored);
	endfunction

	// Table entry checked against the predictor
	function automatic void plan_row(input logic [1:0] o, input logic [7:0] d, input logic e,
			input int reps);
		plan_row_t row;
		row.op = o;
		row.data = d;
		row.eop = e;
		row.reps = reps;
		row.known = 1'b0;
		row.res = '0;
		directed_plan.push_back(row);
	endfunction

	// Table entry whose result is written out by hand
	function automatic void plan_known(input logic [1:0] o, input logic [7:0] d, input logic e,
			input logic [7:0] xd, input logic xl, input logic [1:0] xs, input int xn);
		plan_row_t row;
		row.op = o;
		row.data = d;
		row.eop = e;
		row.reps = 1;
		row.known = 1'b1;
		row.res.data = xd;
		row.res.last = xl;
		row.res.status = xs;
		row.res.stored = COUNT_W'(xn);
		directed_plan.push_back(row);
	endfunction

	// Present one request and hold it until the block takes it. start stays
	// high on return unless an idle gap follows, so back-to-back requests need no extra assignment.
	task automatic issue_request(input logic [1:0] req_op, input logic [7:0] req_byte,
			input logic req_eop, input bit known, input pkt_result_t known_res);
		pkt_result_t pred;
		pending_t    owed;
		op            <= req_op;
		data_in       <= req_byte;
		end_of_packet <= req_eop;
		start         <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		// Taken at this edge: record what it must produce
		model_request(req_op, req_byte, req_eop, pred);
		owed.res = known ? known_res : pred;
		owed.id  = n_requests;
		expected_results.push_back(owed);
		n_requests++;
		// Occasionally hold off the next request with start low
		if (idling_on && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic void check_field(input string name, input int id,
			input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: request %0d %s expected %0h got %0h", $time, id, name, want, got);
		end
	endfunction

	// Results last one cycle and cannot be stalled: take them at the edge
	// that closes the done cycle and match them against the oldest owed one.
	always @(posedge clk) begin : check_results
		pending_t owed;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				n_errors++;
				$display("%0t: result with no request owed: data_out=%0h last_byte=%0b status=%0d",
					$time, data_out, last_byte, status);
			end else begin
				owed = expected_results.pop_front();
				check_field("data_out", owed.id, 16'(owed.res.data), 16'(data_out));
				check_field("last_byte", owed.id, 16'(owed.res.last), 16'(last_byte));
				check_field("status", owed.id, 16'(owed.res.status), 16'(status));
				check_field("packets_stored", owed.id, 16'(owed.res.stored),
					16'(packets_stored));
				n_results++;
				if (owed.res.last)
					n_packets_out++;
				if (owed.res.status == ST_DROP)
					n_dropped++;
				if (owed.res.status == ST_TRUNC)
					n_truncated++;
				if (owed.res.status == ST_EMPTY)
					n_empty++;
				if (owed.res.stored > peak_stored)
					peak_stored = owed.res.stored;
			end
		end
	end

	initial begin : stimulus
		int          left_in_packet;
		int          pop_pct;
		int          pick;
		logic        eop;
		pkt_result_t unused_res;

		empty_queue_model();
		unused_res = '0;
		left_in_packet = 0;
		pop_pct = 25;

		// Hold reset, then release on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty queue, header layout, open packet, full queue,
		// truncation. Rows with a written-out result read directly off the spec.
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b0, ST_EMPTY, 0);
		plan_known(OP_CLEAR, 8'hFF, 1'b1, 8'h00, 1'b0, ST_OK,    0);
		plan_known(OP_PUSH,  8'h00, 1'b1, 8'h00, 1'b0, ST_OK,    1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h01, 1'b0, ST_OK,    1);
		plan_known(OP_POP,   8'hFF, 1'b1, 8'h00, 1'b0, ST_OK,    1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b1, ST_OK,    0);
		plan_known(OP_PUSH,  8'hFF, 1'b0, 8'h00, 1'b0, ST_OK,    0);
		plan_known(OP_PUSH,  8'hA5, 1'b0, 8'h00, 1'b0, ST_OK,    0);
		// Pops see only committed packets, not the one being pushed
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b0, ST_EMPTY, 0);
		plan_known(OP_PUSH,  8'h5A, 1'b1, 8'h00, 1'b0, ST_OK,    1);
		plan_row(OP_POP, 8'h00, 1'b0, 7);
		// Clear drops an open packet and restarts the sequence
		plan_known(OP_PUSH,  8'h3C, 1'b0, 8'h00, 1'b0, ST_OK,    0);
		plan_known(OP_CLEAR, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    0);
		// Fill every slot, then a whole packet must be dropped
		plan_row(OP_PUSH, 8'h01, 1'b1, SLOTS);
		plan_known(OP_PUSH,  8'h5A, 1'b0, 8'h00, 1'b0, ST_DROP,  SLOTS);
		plan_known(OP_PUSH,  8'hC3, 1'b1, 8'h00, 1'b0, ST_DROP,  SLOTS);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h01, 1'b0, ST_OK,    SLOTS);
		plan_row(OP_POP, 8'h00, 1'b0, 4);
		plan_known(OP_CLEAR, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK,    0);
		// Overlong packet: extra bytes discarded, end mark still commits
		plan_row(OP_PUSH, 8'h11, 1'b0, MAX_PAYLOAD);
		plan_known(OP_PUSH,  8'hEE, 1'b0, 8'h00, 1'b0, ST_TRUNC, 0);
		plan_known(OP_PUSH,  8'h77, 1'b1, 8'h00, 1'b0, ST_TRUNC, 1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'hFF, 1'b0, ST_OK,    1);
		plan_row(OP_POP, 8'h00, 1'b0, MAX_PAYLOAD + HEADER_BYTES - 1);
		plan_known(OP_POP,   8'h00, 1'b0, 8'h00, 1'b0, ST_EMPTY, 0);

		foreach (directed_plan[k])
			repeat (directed_plan[k].reps)
				issue_request(directed_plan[k].op, directed_plan[k].data,
					directed_plan[k].eop, directed_plan[k].known, directed_plan[k].res);

		// Random part: mostly well-formed packets with random bytes, interleaved
		// with pops. The pop share swings between phases so the queue both builds
		// up and drains to empty. A few early end marks, stray clears and
		// overlong packets break the pattern.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			idling_on = !(i >= 30 && i < 80);
			if (i % PHASE_LEN == 0)
				pop_pct = ((i / PHASE_LEN) % 2 == 1) ? 70 : 25;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				issue_request(OP_CLEAR, 8'($urandom), 1'($urandom), 1'b0, unused_res);
				left_in_packet = 0;
			end else if (pick < 2 + pop_pct) begin
				issue_request(OP_POP, 8'($urandom), 1'($urandom), 1'b0, unused_res);
			end else begin
				if (left_in_packet == 0)
					left_in_packet = ($urandom_range(0, 59) == 0) ?
						$urandom_range(MAX_PAYLOAD - 5, MAX_PAYLOAD + 3) :
						$urandom_range(1, 10);
				eop = (left_in_packet == 1) || ($urandom_range(0, 99) == 0);
				issue_request(OP_PUSH, 8'($urandom), eop, 1'b0, unused_res);
				left_in_packet = eop ? 0 : left_in_packet - 1;
			end
		end

		// Stop issuing, collect what is owed, then watch for stray results
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests, checked %0d results: %0d packets read out, peak of %0d stored",
			n_requests, n_results, n_packets_out, peak_stored);
		$display("Seen %0d dropped bytes, %0d truncated bytes, %0d pops on an empty queue",
			n_dropped, n_truncated, n_empty);
		if (n_errors == 0) begin
			$display("tb_framed_packet_queue_core: PASS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("tb_framed_packet_queue_core: FAIL");
		end
		$finish;
	end

endmodule
